// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk_i and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define XUD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define XUD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/xud_pkg.sv -----
// ----------------------------------------------------------------------------
// xud_pkg
// shared types, codes and keyword tables of the uri decoder and splitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xud_pkg;

  localparam int MaxUriBytes  = 256;
  localparam int MaxRootBytes = 32;
  localparam int CntW         = 9;
  localparam int RootLenW     = 6;
  localparam int NumAuid      = 6;
  localparam int NumTree      = 2;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxUriBytes);

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_TOO_LONG = 4'd1;
  localparam logic [3:0] ST_BAD_ESC  = 4'd2;
  localparam logic [3:0] ST_SHORT    = 4'd3;
  localparam logic [3:0] ST_ROOT_MIS = 4'd4;
  localparam logic [3:0] ST_BAD_AUID = 4'd5;
  localparam logic [3:0] ST_BAD_TREE = 4'd6;
  localparam logic [3:0] ST_NO_UID   = 4'd7;
  localparam logic [3:0] ST_NO_DOC   = 4'd8;

  localparam logic [2:0] REG_ROOT_PRESENT = 3'd0;
  localparam logic [2:0] REG_ROOT_LENGTH  = 3'd1;
  localparam logic [2:0] REG_ROOT_B0      = 3'd2;
  localparam logic [2:0] REG_ROOT_B1      = 3'd3;
  localparam logic [2:0] REG_ROOT_B2      = 3'd4;
  localparam logic [2:0] REG_ROOT_B3      = 3'd5;

  localparam logic [7:0] CHR_SLASH = 8'h2f;
  localparam logic [7:0] CHR_TILDE = 8'h7e;
  localparam logic [7:0] CHR_PCT   = 8'h25;

  localparam int AuidLen [NumAuid] = '{11, 34, 13, 18, 15, 10};
  localparam logic [2:0] AuidType [NumAuid] = '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4};
  localparam logic [34*8-1:0] AuidTxt [NumAuid] = '{
    "pres-rules/",
    "org.openmobilealliance.pres-rules/",
    "rls-services/",
    "pidf-manipulation/",
    "resource-lists/",
    "xcap-caps/"
  };

  localparam int TreeLen [NumTree] = '{6, 7};
  localparam logic [7*8-1:0] TreeTxt [NumTree] = '{"users/", "global/"};

  // one decoded word handed from the front to the back
  typedef struct packed {
    logic [7:0] dbyte;
    logic       bvalid;
    logic       last;
    logic       too_long;
    logic       bad_esc;
  } word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] auid_char(input int idx, input logic [5:0] pos);
    int base;
    base = (AuidLen[idx] - 1 - int'(pos)) * 8;
    return AuidTxt[idx][base +: 8];
  endfunction

  function automatic logic [7:0] tree_char(input int idx, input logic [5:0] pos);
    int base;
    base = (TreeLen[idx] - 1 - int'(pos)) * 8;
    return TreeTxt[idx][base +: 8];
  endfunction

  // bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/xud_front.sv -----
// ----------------------------------------------------------------------------
// xud_front
// percent decoder: turns raw uri bytes into decoded words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xud_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     raw_byte_i,
  input  logic           last_byte_i,
  output xud_pkg::word_t word_o
);
  import xud_pkg::*;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  logic [1:0]      esc_q, esc_d;
  logic [3:0]      hi_q, hi_d;
  logic            err_q, err_d;
  logic [CntW-1:0] rcnt_q, rcnt_d;
  logic [4:0]      hv;
  logic [7:0]      dbyte;
  logic            bvalid;

  always_comb begin
    esc_d  = esc_q;
    hi_d   = hi_q;
    err_d  = err_q;
    rcnt_d = rcnt_q + {{(CntW-1){1'b0}}, (rcnt_q <= MaxCnt)};
    dbyte  = 8'd0;
    bvalid = 1'b0;
    hv     = hex_val(raw_byte_i);
    if (!err_q) begin
      if (esc_q == ESC_IDLE) begin
        if (raw_byte_i == CHR_PCT) begin
          esc_d = ESC_HIGH;
        end else begin
          dbyte  = raw_byte_i;
          bvalid = 1'b1;
        end
      end else if (!hv[4]) begin
        err_d = 1'b1;
        esc_d = ESC_IDLE;
      end else if (esc_q == ESC_HIGH) begin
        hi_d  = hv[3:0];
        esc_d = ESC_LOW;
      end else begin
        dbyte  = {hi_q, hv[3:0]};
        bvalid = 1'b1;
        esc_d  = ESC_IDLE;
      end
    end
  end

  assign word_o.dbyte    = dbyte;
  assign word_o.bvalid   = bvalid;
  assign word_o.last     = last_byte_i;
  assign word_o.too_long = (rcnt_d > MaxCnt);
  assign word_o.bad_esc  = err_d || (esc_d != ESC_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= ESC_IDLE;
      hi_q   <= 4'd0;
      err_q  <= 1'b0;
      rcnt_q <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        esc_q  <= ESC_IDLE;
        hi_q   <= 4'd0;
        err_q  <= 1'b0;
        rcnt_q <= '0;
      end else begin
        esc_q  <= esc_d;
        hi_q   <= hi_d;
        err_q  <= err_d;
        rcnt_q <= rcnt_d;
      end
    end
  end

endmodule

// ----- rtl/xud_fifo.sv -----
// ----------------------------------------------------------------------------
// xud_fifo
// two-entry queue of decoded words between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xud_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  xud_pkg::word_t      wdata_i,
  input  logic                pop_i,
  output xud_pkg::word_t      rdata_o,
  output xud_pkg::fifo_stat_t stat_o
);
  import xud_pkg::*;

  word_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign rdata_o      = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/xud_back.sv -----
// ----------------------------------------------------------------------------
// xud_back
// splitter: tracks root, usage, tree, user id and selector per decoded word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xud_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pop_i,
  input  xud_pkg::word_t             word_i,
  input  logic                       root_present_i,
  input  logic [xud_pkg::RootLenW-1:0] root_length_i,
  input  logic [255:0]               root_flat_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [7:0]                 decoded_byte_o,
  output logic                       byte_valid_o,
  output logic                       done_res_o,
  output logic [3:0]                 status_o,
  output logic [2:0]                 doc_type_o,
  output logic                       global_tree_o,
  output logic [8:0]                 auid_offset_o,
  output logic [8:0]                 user_id_length_o,
  output logic [8:0]                 file_offset_o,
  output logic [8:0]                 file_length_o,
  output logic [8:0]                 node_offset_o,
  output logic [8:0]                 uri_length_o
);
  import xud_pkg::*;

  localparam logic [2:0] PH_ROOT = 3'd0;
  localparam logic [2:0] PH_AUID = 3'd1;
  localparam logic [2:0] PH_TREE = 3'd2;
  localparam logic [2:0] PH_UID  = 3'd3;
  localparam logic [2:0] PH_DOC  = 3'd4;
  localparam logic [2:0] PH_FAIL = 3'd5;

  logic [2:0]         ph_q, ph_d;
  logic [NumAuid-1:0] cand_q, cand_d;
  logic [NumTree-1:0] tc_q, tc_d;
  logic [CntW-1:0]    dcnt_q, dcnt_d;
  logic [CntW-1:0]    seg_off_q, seg_off_d;
  logic [CntW-1:0]    auid_off_q, auid_off_d;
  logic [CntW-1:0]    file_off_q, file_off_d;
  logic [CntW-1:0]    uid_len_q, uid_len_d;
  logic [CntW-1:0]    nss_q, nss_d;
  logic [2:0]         type_q, type_d;
  logic               glob_q, glob_d;
  logic [3:0]         perr_q, perr_d;
  logic               root_mis_q, root_mis_d;
  logic               root_stop_q, root_stop_d;
  logic [7:0]         prev_q, prev_d;
  logic [7:0]         prev2_q, prev2_d;
  logic [7:0]         nss_pre_q, nss_pre_d;
  logic               zero_q, zero_d;
  logic               found_q, found_d;

  logic [RootLenW-1:0] erl;
  logic [7:0]          c, rbyte;
  logic [CntW-1:0]     d, j, n, flen;
  logic                do_auid, adone;
  logic [NumTree-1:0]  tdone;
  logic [3:0]          st;

  logic out_valid_q;
  logic [7:0] obyte_q;
  logic obv_q, odone_q, oglob_q;
  logic [3:0] ost_q;
  logic [2:0] otype_q;
  logic [8:0] oauid_q, ouid_q, ofoff_q, oflen_q, onode_q, olen_q;

  assign c     = word_i.dbyte;
  assign d     = dcnt_q;
  assign rbyte = root_flat_i[{d[4:0], 3'b000} +: 8];

  always_comb begin
    if (!root_present_i) begin
      erl = '0;
    end else if (root_length_i > RootLenW'(MaxRootBytes)) begin
      erl = RootLenW'(MaxRootBytes);
    end else begin
      erl = root_length_i;
    end
  end

  always_comb begin
    ph_d        = ph_q;
    cand_d      = cand_q;
    tc_d        = tc_q;
    dcnt_d      = dcnt_q;
    seg_off_d   = seg_off_q;
    auid_off_d  = auid_off_q;
    file_off_d  = file_off_q;
    uid_len_d   = uid_len_q;
    nss_d       = nss_q;
    type_d      = type_q;
    glob_d      = glob_q;
    perr_d      = perr_q;
    root_mis_d  = root_mis_q;
    root_stop_d = root_stop_q;
    prev_d      = prev_q;
    prev2_d     = prev2_q;
    nss_pre_d   = nss_pre_q;
    zero_d      = zero_q;
    found_d     = found_q;
    do_auid     = 1'b0;
    adone       = 1'b0;
    tdone       = '0;
    j           = d - seg_off_q;
    if (word_i.bvalid) begin
      dcnt_d = dcnt_q + {{(CntW-1){1'b0}}, (dcnt_q <= MaxCnt)};
      if (!zero_q && !found_q && prev_q == CHR_TILDE && c == CHR_TILDE) begin
        found_d   = 1'b1;
        nss_d     = d - 9'd1;
        nss_pre_d = prev2_q;
      end
      if (c == 8'd0) begin
        zero_d = 1'b1;
      end
      prev2_d = prev_q;
      prev_d  = c;
      if (perr_q == ST_OK) begin
        case (ph_q)
          PH_ROOT: begin
            if (d < {3'b000, erl}) begin
              if (!root_stop_q) begin
                if (c != rbyte) begin
                  root_mis_d = 1'b1;
                end else if (c == 8'd0) begin
                  root_stop_d = 1'b1;
                end
              end
            end else if (c == CHR_SLASH) begin
              ph_d       = PH_AUID;
              auid_off_d = d + 9'd1;
              seg_off_d  = d + 9'd1;
            end else begin
              auid_off_d = d;
              seg_off_d  = d;
              j          = '0;
              do_auid    = 1'b1;
            end
          end
          PH_AUID: begin
            do_auid = 1'b1;
          end
          PH_TREE: begin
            for (int t = 0; t < NumTree; t++) begin
              if (tc_q[t] && j < CntW'(TreeLen[t])) begin
                if (c == tree_char(t, j[5:0])) begin
                  if (j == CntW'(TreeLen[t] - 1)) begin
                    tdone[t] = 1'b1;
                  end
                end else begin
                  tc_d[t] = 1'b0;
                end
              end
            end
            if (tdone[0]) begin
              ph_d      = PH_UID;
              seg_off_d = d + 9'd1;
              glob_d    = 1'b0;
            end else if (tdone[1]) begin
              ph_d       = PH_DOC;
              file_off_d = d + 9'd1;
              glob_d     = 1'b1;
            end else if (tc_d == '0) begin
              perr_d = ST_BAD_TREE;
              ph_d   = PH_FAIL;
            end
          end
          PH_UID: begin
            if (c == CHR_SLASH) begin
              uid_len_d  = d - seg_off_q;
              file_off_d = d + 9'd1;
              ph_d       = PH_DOC;
            end else if (c == 8'd0) begin
              perr_d = ST_NO_UID;
              ph_d   = PH_FAIL;
            end
          end
          default: begin
          end
        endcase
        if (do_auid) begin
          ph_d = PH_AUID;
          for (int i = 0; i < NumAuid; i++) begin
            if (cand_q[i] && j < CntW'(AuidLen[i])) begin
              if (c == auid_char(i, j[5:0])) begin
                if (j == CntW'(AuidLen[i] - 1)) begin
                  adone  = 1'b1;
                  type_d = AuidType[i];
                end
              end else begin
                cand_d[i] = 1'b0;
              end
            end
          end
          if (adone) begin
            ph_d      = PH_TREE;
            seg_off_d = d + 9'd1;
          end else if (cand_d == '0) begin
            perr_d = ST_BAD_AUID;
            ph_d   = PH_FAIL;
          end
        end
      end
    end
  end

  // summary from the state after this word
  always_comb begin
    n    = dcnt_d;
    flen = '0;
    if (word_i.too_long) begin
      st = ST_TOO_LONG;
    end else if (word_i.bad_esc) begin
      st = ST_BAD_ESC;
    end else if (root_present_i && {3'b000, erl} >= n) begin
      st = ST_SHORT;
    end else if (root_mis_d) begin
      st = ST_ROOT_MIS;
    end else if (perr_d != ST_OK) begin
      st = perr_d;
    end else begin
      case (ph_d)
        PH_TREE: st = (seg_off_d == n) ? ST_BAD_AUID : ST_BAD_TREE;
        PH_UID:  st = (seg_off_d == n) ? ST_BAD_TREE : ST_NO_UID;
        PH_DOC: begin
          if (glob_d && file_off_d == n) begin
            st = ST_BAD_TREE;
          end else if (!found_d) begin
            if (n == file_off_d) begin
              st = ST_NO_DOC;
            end else begin
              st   = ST_OK;
              flen = n - file_off_d - {8'd0, (prev_d == CHR_SLASH)};
            end
          end else if (nss_d <= file_off_d) begin
            st = ST_NO_DOC;
          end else begin
            st   = ST_OK;
            flen = nss_d - file_off_d - {8'd0, (nss_pre_d == CHR_SLASH)};
          end
        end
        default: st = ST_BAD_AUID;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_ROOT;
      cand_q      <= '1;
      tc_q        <= '1;
      dcnt_q      <= '0;
      seg_off_q   <= '0;
      auid_off_q  <= '0;
      file_off_q  <= '0;
      uid_len_q   <= '0;
      nss_q       <= '0;
      type_q      <= '0;
      glob_q      <= 1'b0;
      perr_q      <= ST_OK;
      root_mis_q  <= 1'b0;
      root_stop_q <= 1'b0;
      prev_q      <= '0;
      prev2_q     <= '0;
      nss_pre_q   <= '0;
      zero_q      <= 1'b0;
      found_q     <= 1'b0;
    end else if (pop_i) begin
      if (word_i.last) begin
        ph_q        <= PH_ROOT;
        cand_q      <= '1;
        tc_q        <= '1;
        dcnt_q      <= '0;
        seg_off_q   <= '0;
        auid_off_q  <= '0;
        file_off_q  <= '0;
        uid_len_q   <= '0;
        nss_q       <= '0;
        type_q      <= '0;
        glob_q      <= 1'b0;
        perr_q      <= ST_OK;
        root_mis_q  <= 1'b0;
        root_stop_q <= 1'b0;
        prev_q      <= '0;
        prev2_q     <= '0;
        nss_pre_q   <= '0;
        zero_q      <= 1'b0;
        found_q     <= 1'b0;
      end else begin
        ph_q        <= ph_d;
        cand_q      <= cand_d;
        tc_q        <= tc_d;
        dcnt_q      <= dcnt_d;
        seg_off_q   <= seg_off_d;
        auid_off_q  <= auid_off_d;
        file_off_q  <= file_off_d;
        uid_len_q   <= uid_len_d;
        nss_q       <= nss_d;
        type_q      <= type_d;
        glob_q      <= glob_d;
        perr_q      <= perr_d;
        root_mis_q  <= root_mis_d;
        root_stop_q <= root_stop_d;
        prev_q      <= prev_d;
        prev2_q     <= prev2_d;
        nss_pre_q   <= nss_pre_d;
        zero_q      <= zero_d;
        found_q     <= found_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      obyte_q <= word_i.dbyte;
      obv_q   <= word_i.bvalid;
      odone_q <= word_i.last;
      ost_q   <= word_i.last ? st : ST_OK;
      olen_q  <= word_i.last ? n : '0;
      if (word_i.last && st == ST_OK) begin
        otype_q <= type_d;
        oglob_q <= glob_d;
        oauid_q <= auid_off_d;
        ouid_q  <= glob_d ? '0 : uid_len_d;
        ofoff_q <= file_off_d;
        oflen_q <= flen;
        onode_q <= found_d ? (nss_d + 9'd2) : '0;
      end else begin
        otype_q <= '0;
        oglob_q <= 1'b0;
        oauid_q <= '0;
        ouid_q  <= '0;
        ofoff_q <= '0;
        oflen_q <= '0;
        onode_q <= '0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign decoded_byte_o   = obyte_q;
  assign byte_valid_o     = obv_q;
  assign done_res_o       = odone_q;
  assign status_o         = ost_q;
  assign doc_type_o       = otype_q;
  assign global_tree_o    = oglob_q;
  assign auid_offset_o    = oauid_q;
  assign user_id_length_o = ouid_q;
  assign file_offset_o    = ofoff_q;
  assign file_length_o    = oflen_q;
  assign node_offset_o    = onode_q;
  assign uri_length_o     = olen_q;

endmodule

// ----- rtl/xcap_uri_decode_and_split.sv -----
// ----------------------------------------------------------------------------
// xcap_uri_decode_and_split
// streaming percent decoder and splitter for xcap request uris
// ----------------------------------------------------------------------------
// raw uri bytes enter on the input channel (valid/ready), the final byte
// flagged by last_byte_i, one per cycle while in_ready_o is high. every
// accepted word yields exactly one result word on the output channel: the
// decoded byte when one completes and, on the final byte, the summary (status,
// document type, tree, offsets). the decoded word passes through the two-entry
// queue into the splitter's output register. throughput is one word per cycle
// while the receiver is ready, limited by the per-byte splitter update; the
// decoder keeps accepting while a result waits. when the receiver stalls, the
// queue fills and input ready drops after two further words. reset clears all
// per-uri state and the root registers; after each final byte the per-uri state
// returns to its reset value. the user must write the root registers over the
// apb port only while no uri is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcap_uri_decode_and_split (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  raw_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  decoded_byte_o,
  output logic        byte_valid_o,
  output logic        done_res_o,
  output logic [3:0]  status_o,
  output logic [2:0]  doc_type_o,
  output logic        global_tree_o,
  output logic [8:0]  auid_offset_o,
  output logic [8:0]  user_id_length_o,
  output logic [8:0]  file_offset_o,
  output logic [8:0]  file_length_o,
  output logic [8:0]  node_offset_o,
  output logic [8:0]  uri_length_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import xud_pkg::*;

  logic                root_present_q;
  logic [RootLenW-1:0] root_length_q;
  logic [3:0][63:0]    root_bytes_q;
  logic                cfg_wr;
  logic                accept;
  logic                pop;
  word_t               fw, bw;
  fifo_stat_t          fstat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_present_q <= 1'b0;
      root_length_q  <= '0;
      root_bytes_q   <= '0;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_ROOT_PRESENT: root_present_q  <= pwdata[0];
        REG_ROOT_LENGTH:  root_length_q   <= pwdata[RootLenW-1:0];
        REG_ROOT_B0:      root_bytes_q[0] <= pwdata;
        REG_ROOT_B1:      root_bytes_q[1] <= pwdata;
        REG_ROOT_B2:      root_bytes_q[2] <= pwdata;
        REG_ROOT_B3:      root_bytes_q[3] <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_ROOT_PRESENT: prdata = {63'd0, root_present_q};
      REG_ROOT_LENGTH:  prdata = {{(64-RootLenW){1'b0}}, root_length_q};
      REG_ROOT_B0:      prdata = root_bytes_q[0];
      REG_ROOT_B1:      prdata = root_bytes_q[1];
      REG_ROOT_B2:      prdata = root_bytes_q[2];
      REG_ROOT_B3:      prdata = root_bytes_q[3];
      default:          prdata = '0;
    endcase
  end

  assign in_ready_o = !fstat.full;
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = !fstat.empty && (!out_valid_o || out_ready_i);

  xud_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .raw_byte_i  (raw_byte_i),
    .last_byte_i (last_byte_i),
    .word_o      (fw)
  );

  xud_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (fw),
    .pop_i   (pop),
    .rdata_o (bw),
    .stat_o  (fstat)
  );

  xud_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_i            (pop),
    .word_i           (bw),
    .root_present_i   (root_present_q),
    .root_length_i    (root_length_q),
    .root_flat_i      (root_bytes_q),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .decoded_byte_o   (decoded_byte_o),
    .byte_valid_o     (byte_valid_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .doc_type_o       (doc_type_o),
    .global_tree_o    (global_tree_o),
    .auid_offset_o    (auid_offset_o),
    .user_id_length_o (user_id_length_o),
    .file_offset_o    (file_offset_o),
    .file_length_o    (file_length_o),
    .node_offset_o    (node_offset_o),
    .uri_length_o     (uri_length_o)
  );

`include "assert_macros.svh"

  `XUD_ASSERT_SAME(a_fail_clears, out_valid_o && status_o != ST_OK, file_offset_o == 9'd0 && doc_type_o == 3'd0 && node_offset_o == 9'd0)
  `XUD_ASSERT_SAME(a_status_on_done, out_valid_o && !done_res_o, status_o == ST_OK && uri_length_o == 9'd0)
  `XUD_ASSERT_SAME(a_ok_order, out_valid_o && done_res_o && status_o == ST_OK, file_offset_o > auid_offset_o)
  `XUD_ASSERT_NEXT(a_pop_shows, pop, out_valid_o)

endmodule

// ----- verif/xud_checker.sv -----
// ----------------------------------------------------------------------------
// xud_checker
// watches the input, output and register ports of the uri decoder, predicts
// every result word from its own model of the decoder and splitter, and
// compares each result field by field with the oldest expected word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xud_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  raw_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  decoded_byte_i,
  input  logic        byte_valid_i,
  input  logic        done_res_i,
  input  logic [3:0]  status_i,
  input  logic [2:0]  doc_type_i,
  input  logic        global_tree_i,
  input  logic [8:0]  auid_offset_i,
  input  logic [8:0]  user_id_length_i,
  input  logic [8:0]  file_offset_i,
  input  logic [8:0]  file_length_i,
  input  logic [8:0]  node_offset_i,
  input  logic [8:0]  uri_length_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int          err_count_o,
  output int          pending_o
);
  import xud_pkg::*;

  typedef struct packed {
    logic [7:0] dbyte;
    logic       bvalid;
    logic       done;
    logic [3:0] status;
    logic [2:0] dtype;
    logic       glob;
    logic [8:0] auid_off;
    logic [8:0] uid_len;
    logic [8:0] file_off;
    logic [8:0] file_len;
    logic [8:0] node_off;
    logic [8:0] uri_len;
  } summary_t;

  string       auid_names [NumAuid] = '{"pres-rules/", "org.openmobilealliance.pres-rules/",
                                       "rls-services/", "pidf-manipulation/",
                                       "resource-lists/", "xcap-caps/"};
  logic [2:0]  auid_types [NumAuid] = '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4};

  logic        root_on;
  logic [5:0]  root_len;
  logic [63:0] root_b [4];

  int          esc_phase, hi_nib, esc_err, raw_cnt, dec_cnt;
  logic [7:0]  uri_store [MaxUriBytes];
  summary_t    expected_words [$];

  assign pending_o = expected_words.size();

  function automatic int char_at(int i);
    if (i < dec_cnt && i < MaxUriBytes) return uri_store[i];
    return 0;
  endfunction

  function automatic bit has_prefix(int pos, int slen, string lit);
    if (slen <= lit.len()) return 0;
    for (int k = 0; k < lit.len(); k++) begin
      if (char_at(pos + k) != lit[k]) return 0;
    end
    return 1;
  endfunction

  // split the decoded uri; only the summary fields are filled
  function automatic summary_t split_uri();
    summary_t r;
    int n, pos, slen, rl, k, uid, flen, nss, alen;
    bit found, glob;
    r = '0;
    n = dec_cnt;
    pos = 0;
    slen = n;
    uid = 0;
    nss = 0;
    glob = 0;
    found = 0;
    alen = 0;
    if (root_on) begin
      rl = root_len;
      if (rl > MaxRootBytes) rl = MaxRootBytes;
      if (rl >= n) begin
        r.status = ST_SHORT;
        return r;
      end
      for (k = 0; k < rl; k++) begin
        if (char_at(k) != root_b[k >> 3][8 * (k & 7) +: 8]) begin
          r.status = ST_ROOT_MIS;
          return r;
        end
        if (char_at(k) == 0) break;
      end
      pos = rl;
      slen = n - rl;
    end
    if (slen > 0 && char_at(pos) == CHR_SLASH) begin
      pos++;
      slen--;
    end
    r.auid_off = pos[8:0];
    for (int i = 0; i < NumAuid; i++) begin
      if (has_prefix(pos, slen, auid_names[i])) begin
        found = 1;
        r.dtype = auid_types[i];
        alen = auid_names[i].len();
        break;
      end
    end
    if (!found) return '{status: ST_BAD_AUID, default: '0};
    pos += alen;
    slen -= alen;
    if (has_prefix(pos, slen, "users/")) begin
      pos += 6;
      slen -= 6;
    end else if (has_prefix(pos, slen, "global/")) begin
      pos += 7;
      slen -= 7;
      glob = 1;
    end else begin
      return '{status: ST_BAD_TREE, default: '0};
    end
    if (!glob) begin
      k = pos;
      while (k < n && char_at(k) != CHR_SLASH && char_at(k) != 0) k++;
      if (char_at(k) != CHR_SLASH) return '{status: ST_NO_UID, default: '0};
      uid = k - pos;
      pos = k + 1;
      slen -= uid + 1;
    end
    found = 0;
    for (int i = 0; i + 1 < n; i++) begin
      if (char_at(i) == 0) break;
      if (char_at(i) == CHR_TILDE && char_at(i + 1) == CHR_TILDE) begin
        found = 1;
        nss = i;
        break;
      end
    end
    if (!found) begin
      if (slen == 0) return '{status: ST_NO_DOC, default: '0};
      flen = slen;
      if (char_at(pos + slen - 1) == CHR_SLASH) flen--;
    end else begin
      if (nss <= pos) return '{status: ST_NO_DOC, default: '0};
      flen = nss - pos;
      if (char_at(pos + flen - 1) == CHR_SLASH) flen--;
      r.node_off = 9'(nss + 2);
    end
    r.status = ST_OK;
    r.glob = glob;
    r.uid_len = uid[8:0];
    r.file_off = pos[8:0];
    r.file_len = flen[8:0];
    return r;
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void clear_uri();
    esc_phase = 0;
    hi_nib = 0;
    esc_err = 0;
    raw_cnt = 0;
    dec_cnt = 0;
    foreach (uri_store[i]) uri_store[i] = '0;
  endfunction

  function automatic summary_t decode_word(logic [7:0] raw, logic last);
    summary_t e;
    int h;
    e = '0;
    if (raw_cnt <= MaxUriBytes) raw_cnt++;
    if (esc_err == 0) begin
      if (esc_phase == 0) begin
        if (raw == CHR_PCT) esc_phase = 1;
        else begin
          e.dbyte = raw;
          e.bvalid = 1;
        end
      end else begin
        h = hex_digit(raw);
        if (h < 0) begin
          esc_err = 1;
          esc_phase = 0;
        end else if (esc_phase == 1) begin
          hi_nib = h;
          esc_phase = 2;
        end else begin
          e.dbyte = 8'(hi_nib * 16 + h);
          e.bvalid = 1;
          esc_phase = 0;
        end
      end
    end
    if (e.bvalid) begin
      if (dec_cnt < MaxUriBytes) uri_store[dec_cnt] = e.dbyte;
      if (dec_cnt <= MaxUriBytes) dec_cnt++;
    end
    if (last) begin
      summary_t s;
      if (raw_cnt > MaxUriBytes) s = '{status: ST_TOO_LONG, default: '0};
      else if (esc_err != 0 || esc_phase != 0) s = '{status: ST_BAD_ESC, default: '0};
      else s = split_uri();
      s.dbyte = e.dbyte;
      s.bvalid = e.bvalid;
      s.done = 1;
      s.uri_len = dec_cnt[8:0];
      e = s;
      clear_uri();
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_on <= 1'b0;
      root_len <= '0;
      root_b <= '{default: '0};
      err_count_o <= 0;
      expected_words.delete();
      clear_uri();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_ROOT_PRESENT: root_on <= pwdata[0];
          REG_ROOT_LENGTH:  root_len <= pwdata[5:0];
          REG_ROOT_B0:      root_b[0] <= pwdata;
          REG_ROOT_B1:      root_b[1] <= pwdata;
          REG_ROOT_B2:      root_b[2] <= pwdata;
          REG_ROOT_B3:      root_b[3] <= pwdata;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          summary_t w;
          w = expected_words.pop_front();
          if (decoded_byte_i !== w.dbyte) report_mismatch("decoded_byte", decoded_byte_i, w.dbyte);
          if (byte_valid_i !== w.bvalid) report_mismatch("byte_valid", byte_valid_i, w.bvalid);
          if (done_res_i !== w.done) report_mismatch("done_res", done_res_i, w.done);
          if (status_i !== w.status) report_mismatch("status", status_i, w.status);
          if (doc_type_i !== w.dtype) report_mismatch("doc_type", doc_type_i, w.dtype);
          if (global_tree_i !== w.glob) report_mismatch("global_tree", global_tree_i, w.glob);
          if (auid_offset_i !== w.auid_off)
            report_mismatch("auid_offset", auid_offset_i, w.auid_off);
          if (user_id_length_i !== w.uid_len)
            report_mismatch("user_id_length", user_id_length_i, w.uid_len);
          if (file_offset_i !== w.file_off)
            report_mismatch("file_offset", file_offset_i, w.file_off);
          if (file_length_i !== w.file_len)
            report_mismatch("file_length", file_length_i, w.file_len);
          if (node_offset_i !== w.node_off)
            report_mismatch("node_offset", node_offset_i, w.node_off);
          if (uri_length_i !== w.uri_len)
            report_mismatch("uri_length", uri_length_i, w.uri_len);
        end
      end
      if (in_valid_i && in_ready_i) expected_words.push_back(decode_word(raw_byte_i, last_byte_i));
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the uri decoder and splitter: builds xcap uris, well formed
// and broken, percent-encodes them at random, drives them under several root
// prefix settings with random idling and stalls, and reports the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import xud_pkg::*;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, last_byte_i;
  logic [7:0]  raw_byte_i;
  logic        out_valid_o, out_ready_i;
  logic [7:0]  decoded_byte_o;
  logic        byte_valid_o, done_res_o, global_tree_o;
  logic [3:0]  status_o;
  logic [2:0]  doc_type_o;
  logic [8:0]  auid_offset_o, user_id_length_o, file_offset_o, file_length_o;
  logic [8:0]  node_offset_o, uri_length_o;
  logic        psel, penable, pwrite, pready;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;
  int          err_count, pending, cycles;
  bit          calm, hold_req;
  logic [7:0]  root_text [$];

  string auid_names [NumAuid] = '{"pres-rules/", "org.openmobilealliance.pres-rules/",
                                 "rls-services/", "pidf-manipulation/",
                                 "resource-lists/", "xcap-caps/"};

  xcap_uri_decode_and_split u_dut (.*);

  xud_checker u_chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .raw_byte_i, .last_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .decoded_byte_i(decoded_byte_o), .byte_valid_i(byte_valid_o),
    .done_res_i(done_res_o), .status_i(status_o), .doc_type_i(doc_type_o),
    .global_tree_i(global_tree_o), .auid_offset_i(auid_offset_o),
    .user_id_length_i(user_id_length_o), .file_offset_i(file_offset_o),
    .file_length_i(file_length_o), .node_offset_i(node_offset_o),
    .uri_length_i(uri_length_o),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .err_count_o(err_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 300000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 10);
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_root(bit on, logic [5:0] len, int mode);
    logic [63:0] b [4];
    root_text.delete();
    for (int k = 0; k < MaxRootBytes; k++) begin
      logic [7:0] c;
      c = (mode == 0) ? 8'($urandom_range(97, 122)) :
          (mode == 1) ? 8'hff : 8'($urandom_range(1, 255));
      if (k == 0 && mode == 0) c = CHR_SLASH;
      b[k >> 3][8 * (k & 7) +: 8] = c;
      if (k < len) root_text.push_back(c);
    end
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
    apb_write(REG_ROOT_PRESENT, {63'd0, on});
    apb_write(REG_ROOT_LENGTH, {58'd0, len});
    apb_write(REG_ROOT_B0, b[0]);
    apb_write(REG_ROOT_B1, b[1]);
    apb_write(REG_ROOT_B2, b[2]);
    apb_write(REG_ROOT_B3, b[3]);
    if (!on) root_text.delete();
  endtask

  // valid stays high into the next word unless an idle cycle comes between
  task automatic send_word(logic [7:0] b, logic last);
    bit took;
    if (!calm) begin
      while ($urandom_range(99) < 10) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    raw_byte_i <= b;
    last_byte_i <= last;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic stop_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_uri(logic [7:0] q [$]);
    foreach (q[i]) send_word(q[i], i == q.size() - 1);
  endtask

  function automatic logic [7:0] hex_char(int v);
    bit upper;
    upper = $urandom_range(1);
    if (v < 10) return 8'("0" + v);
    return 8'((upper ? "A" : "a") + v - 10);
  endfunction

  function automatic void push_text(ref logic [7:0] q [$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void push_word(ref logic [7:0] q [$], input int n);
    string pool;
    pool = "abcxyz09.-_@:";
    repeat (n) q.push_back(pool[$urandom_range(pool.len() - 1)]);
  endfunction

  // one uri, decoded form first, then percent-encoded and maybe broken
  function automatic void build_uri(ref logic [7:0] raw [$], input bit huge);
    logic [7:0] d [$];
    int sel;
    bit users;
    raw.delete();
    if (root_text.size() > 0) begin
      sel = $urandom_range(99);
      d = root_text;
      if (sel < 5) d[$urandom_range(d.size() - 1)] ^= 8'(1 << $urandom_range(7));
      else if (sel < 10) begin
        while (d.size() > 1 && $urandom_range(3) != 0) void'(d.pop_back());
        raw = d;
        return;
      end
    end
    if ($urandom_range(99) < 70) d.push_back(CHR_SLASH);
    if ($urandom_range(99) < 90) push_text(d, auid_names[$urandom_range(NumAuid - 1)]);
    else begin
      push_word(d, $urandom_range(1, 8));
      d.push_back(CHR_SLASH);
    end
    sel = $urandom_range(99);
    users = sel < 45;
    if (users) push_text(d, "users/");
    else if (sel < 85) push_text(d, "global/");
    else push_text(d, "usr/");
    if (users) begin
      push_word(d, $urandom_range(8));
      if ($urandom_range(99) < 90) d.push_back(CHR_SLASH);
    end
    push_word(d, huge ? 280 : $urandom_range(12));
    if ($urandom_range(99) < 30) d.push_back(CHR_SLASH);
    if ($urandom_range(99) < 20) begin
      push_text(d, "~~");
      push_word(d, $urandom_range(6));
    end
    if ($urandom_range(99) < 5) d.insert($urandom_range(d.size()), 8'h00);
    if ($urandom_range(99) < 5) d.insert($urandom_range(d.size()), CHR_TILDE);
    foreach (d[i]) begin
      if (d[i] == CHR_PCT || d[i] >= 8'h80 || $urandom_range(99) < 15) begin
        raw.push_back(CHR_PCT);
        raw.push_back(hex_char(d[i][7:4]));
        raw.push_back(hex_char(d[i][3:0]));
      end else begin
        raw.push_back(d[i]);
      end
    end
    sel = $urandom_range(99);
    if (sel < 4) begin
      int p;
      p = $urandom_range(raw.size());
      raw.insert(p, 8'($urandom_range(1) ? "g" : "/"));
      raw.insert(p, CHR_PCT);
    end else if (sel < 7) begin
      raw.push_back(CHR_PCT);
      if ($urandom_range(1)) raw.push_back(hex_char($urandom_range(15)));
    end else if (sel < 12) begin
      repeat ($urandom_range(1, 6)) raw.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic run_random(int n_words, bit with_huge);
    logic [7:0] q [$];
    int sent;
    sent = 0;
    while (sent < n_words) begin
      build_uri(q, with_huge && sent == 0);
      calm = (sent > n_words / 3 && sent < n_words / 2);
      send_uri(q);
      sent += q.size();
    end
    calm = 1'b0;
    stop_input();
  endtask

  initial begin
    logic [7:0] q [$];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    raw_byte_i = '0;
    last_byte_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed uris - good global uri, open escape, bad hex digit, 0xff then zero byte
    q.delete();
    push_text(q, "xcap-caps/global/d");
    send_uri(q);
    q = '{CHR_PCT};
    send_uri(q);
    q = '{CHR_PCT, "4", "g"};
    send_uri(q);
    q = '{8'hff, 8'h00};
    send_uri(q);

    // long receiver hold-off while the sender keeps pushing
    hold_req <= 1'b1;
    run_random(150, 1'b1);

    // sender pauses until everything has drained
    wait (pending == 0);
    run_random(100, 1'b0);

    set_root(1'b1, 6'd0, 0);
    run_random(60, 1'b0);
    set_root(1'b1, 6'd6, 0);
    run_random(120, 1'b0);
    set_root(1'b1, 6'd32, 2);
    run_random(120, 1'b0);
    set_root(1'b1, 6'd63, 1);
    run_random(80, 1'b0);
    set_root(1'b0, 6'd5, 0);
    run_random(60, 1'b0);

    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/xud_pkg.sv
rtl/xud_front.sv
rtl/xud_fifo.sv
rtl/xud_back.sv
rtl/xcap_uri_decode_and_split.sv
verif/xud_checker.sv
verif/tb_top.sv
